### src/ghs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ghs_pkg;

   localparam int IDX_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int COEFF_W      = 32;
   localparam int SCALE_W      = 48;
   localparam int HEAT_W       = 48;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int GRID_MAX_DEF = 1024;
   localparam int QUEUE_DEPTH  = 4;
   localparam int ROOT_BITS    = 16;
   localparam int ROOT_W       = 32;

   localparam logic [SIZE_W-1:0]  SIZE_X_RST   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0]  SIZE_Y_RST   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0]  CENTER_X_RST = '0;
   localparam logic [SIZE_W-1:0]  CENTER_Y_RST = '0;
   localparam logic [COEFF_W-1:0] COEFF_X_RST  = COEFF_W'(32'd16777216);
   localparam logic [COEFF_W-1:0] COEFF_Y_RST  = COEFF_W'(32'd8388608);
   localparam logic [SCALE_W-1:0] SCALE_RST    = SCALE_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X   = 3'd0,
      CSR_SIZE_Y   = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_COEFF_X  = 3'd4,
      CSR_COEFF_Y  = 3'd5,
      CSR_SCALE    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  center_x;
      logic [SIZE_W-1:0]  center_y;
      logic [COEFF_W-1:0] coeff_x;
      logic [COEFF_W-1:0] coeff_y;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      logic              oog;
      logic [SIZE_W-1:0] dx;
      logic [SIZE_W-1:0] dy;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_port_type;

   typedef logic [ROOT_BITS:1][ROOT_W-1:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic root_tab_type root_table();
      root_tab_type tab;
      logic [63:0]  r;
      r = isqrt64(64'h8000_0000_0000_0000);
      tab[1] = r[ROOT_W-1:0];
      for (int i = 2; i <= ROOT_BITS; i++) begin
         r = isqrt64({tab[i-1], 32'b0});
         tab[i] = r[ROOT_W-1:0];
      end
      return tab;
   endfunction

   localparam root_tab_type ROOT_TAB = root_table();

   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;

endpackage

`default_nettype wire

### src/ghs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ghs_req_if import ghs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] x_index;
   logic [IDX_W-1:0] y_index;

   modport source (output valid, output x_index, output y_index, input ready);
   modport sink   (input valid, input x_index, input y_index, output ready);
endinterface

`default_nettype wire

### src/ghs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ghs_rsp_if import ghs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HEAT_W-1:0] heat;
   logic              out_of_grid;

   modport source (output valid, output heat, output out_of_grid, input ready);
   modport sink   (input valid, input heat, input out_of_grid, output ready);
endinterface

`default_nettype wire

### src/ghs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ghs_front import ghs_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   ghs_req_if.sink    req,
   input  cfg_type    cfg,
   input  logic       q_full,
   output q_port_type q_wr
);

   logic [SIZE_W-1:0] cx;
   logic [SIZE_W-1:0] cy;
   logic              x_out;
   logic              y_out;

   always_comb begin
      cx = SIZE_W'(req.x_index) + SIZE_W'(1);
      cy = SIZE_W'(req.y_index) + SIZE_W'(1);
      x_out = (SIZE_W'(req.x_index) >= cfg.size_x) ||
              (32'(req.x_index) >= 32'(GRID_MAX));
      y_out = (SIZE_W'(req.y_index) >= cfg.size_y) ||
              (32'(req.y_index) >= 32'(GRID_MAX));

      req.ready = !q_full;
      q_wr.valid = req.valid && !q_full;
      q_wr.item.oog = x_out || y_out;
      q_wr.item.dx = (cx >= cfg.center_x) ? cx - cfg.center_x : cfg.center_x - cx;
      q_wr.item.dy = (cy >= cfg.center_y) ? cy - cfg.center_y : cfg.center_y - cy;
   end

endmodule

`default_nettype wire

### src/ghs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ghs_queue import ghs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_port_type q_wr,
   output logic       q_full,
   input  logic       q_pop,
   output q_port_type q_rd
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   always_comb begin
      q_full = (cnt_ff == CntW'(QUEUE_DEPTH));
      q_rd.valid = (cnt_ff != '0);
      q_rd.item = mem_ff[rd_ptr_ff];
      push = q_wr.valid && !q_full;
      pop = q_pop && q_rd.valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= q_wr.item;
      end
   end

endmodule

`default_nettype wire

### src/ghs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ghs_back import ghs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_port_type q_rd,
   output logic       q_pop,
   ghs_rsp_if.source  rsp
);

   localparam int SqW     = 2 * SIZE_W;
   localparam int PeW     = SqW + COEFF_W;
   localparam int EW      = PeW + 1;
   localparam int EKeepW  = 29;
   localparam int LogW    = 25;
   localparam int TProdW  = EKeepW + LogW;
   localparam int NW      = 6;
   localparam int FW      = ROOT_BITS;
   localparam int HalfW   = SCALE_W / 2;
   localparam int PartW   = HalfW + ROOT_W;
   localparam int PW      = PartW + 1;
   localparam int ShW     = 7;
   localparam int NStages = 4 + ROOT_BITS + 2;

   typedef struct packed {
      logic zero;
      logic oog;
   } flag_type;

   typedef struct packed {
      logic          zero;
      logic          oog;
      logic [NW-1:0] n;
      logic [FW-1:0] f;
   } carry_type;

   localparam logic [ROOT_W-1:0] MOne = ROOT_W'(64'h8000_0000);

   logic [NStages-1:0] vld_ff;
   logic               adv;

   logic [SqW-1:0]    dx2_ff, dy2_ff;
   flag_type          fl1_ff;
   logic [PeW-1:0]    px_ff, py_ff;
   flag_type          fl2_ff;
   logic [EKeepW-1:0] e_ff;
   flag_type          fl3_ff;
   logic [EW-1:0]     e_in;
   logic [TProdW-1:0] t_prod;
   carry_type         c4_in;
   carry_type         c_ff [0:ROOT_BITS];
   logic [ROOT_W-1:0] m_ff [1:ROOT_BITS];
   logic [ROOT_W-1:0] m_in [1:ROOT_BITS];
   logic [PartW-1:0]  hi_ff, lo_ff;
   carry_type         c21_ff;
   logic [PW-1:0]     p_in;
   logic [ShW-1:0]    sh_in;
   logic [PW-1:0]     shifted;
   logic [HEAT_W-1:0] heat_in;
   logic [HEAT_W-1:0] heat_ff;
   logic              oog_ff;

   assign adv = !vld_ff[NStages-1] || rsp.ready;
   assign q_pop = q_rd.valid && adv;

   assign rsp.valid = vld_ff[NStages-1];
   assign rsp.heat = heat_ff;
   assign rsp.out_of_grid = oog_ff;

   always_comb begin
      e_in = EW'(px_ff) + EW'(py_ff);
      t_prod = TProdW'(e_ff) * TProdW'(LOG2E_Q24);
      c4_in.zero = fl3_ff.zero;
      c4_in.oog = fl3_ff.oog;
      c4_in.n = t_prod[TProdW-1:TProdW-NW];
      c4_in.f = t_prod[TProdW-NW-1:TProdW-NW-FW];
   end

   always_comb begin
      logic [ROOT_W-1:0]   src;
      logic [2*ROOT_W-1:0] prod;
      for (int i = 1; i <= ROOT_BITS; i++) begin
         src = (i == 1) ? MOne : m_ff[(i == 1) ? 1 : i - 1];
         prod = (2*ROOT_W)'(src) * (2*ROOT_W)'(ROOT_TAB[i]);
         m_in[i] = c_ff[i-1].f[ROOT_BITS - i] ? prod[2*ROOT_W-1:ROOT_W] : src;
      end
   end

   always_comb begin
      p_in = PW'(hi_ff) + PW'(lo_ff[PartW-1:HalfW]);
      sh_in = ShW'(c21_ff.n) + ShW'(7);
      shifted = p_in >> sh_in;
      if (c21_ff.zero) begin
         heat_in = '0;
      end else if (shifted[PW-1:HEAT_W] != '0) begin
         heat_in = '1;
      end else begin
         heat_in = shifted[HEAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NStages-2:0], q_rd.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff <= SqW'(q_rd.item.dx) * SqW'(q_rd.item.dx);
         dy2_ff <= SqW'(q_rd.item.dy) * SqW'(q_rd.item.dy);
         fl1_ff.zero <= q_rd.item.oog;
         fl1_ff.oog <= q_rd.item.oog;

         px_ff <= PeW'(dx2_ff) * PeW'(cfg.coeff_x);
         py_ff <= PeW'(dy2_ff) * PeW'(cfg.coeff_y);
         fl2_ff <= fl1_ff;

         e_ff <= e_in[EKeepW-1:0];
         fl3_ff.zero <= fl2_ff.zero || (e_in[EW-1:EKeepW] != '0);
         fl3_ff.oog <= fl2_ff.oog;

         c_ff[0] <= c4_in;
         for (int i = 1; i <= ROOT_BITS; i++) begin
            m_ff[i] <= m_in[i];
            c_ff[i] <= c_ff[i-1];
         end

         hi_ff <= PartW'(cfg.scale[SCALE_W-1:HalfW]) * PartW'(m_ff[ROOT_BITS]);
         lo_ff <= PartW'(cfg.scale[HalfW-1:0]) * PartW'(m_ff[ROOT_BITS]);
         c21_ff <= c_ff[ROOT_BITS];

         heat_ff <= heat_in;
         oog_ff <= c21_ff.oog;
      end
   end

endmodule

`default_nettype wire

### src/gaussian_heat_source_grid_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one request per cycle unless the response side stalls; a 4-entry
// queue parts the request side from a 22-stage pipeline whose depth is set by the
// 16 root-multiply stages.
// Reset (synchronous, active high) empties the queue and pipeline and loads the
// register defaults: 1024x1024 grid, center 0,0, coeff_x 1.0, coeff_y 0.5, scale 1.0.
module gaussian_heat_source_grid_core import ghs_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ghs_req_if.sink               req_ch,
   ghs_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   q_port_type q_wr;
   q_port_type q_rd;
   logic       q_full;
   logic       q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIZE_X:   cfg_in.size_x = csr_wdata[SIZE_W-1:0];
            CSR_SIZE_Y:   cfg_in.size_y = csr_wdata[SIZE_W-1:0];
            CSR_CENTER_X: cfg_in.center_x = csr_wdata[SIZE_W-1:0];
            CSR_CENTER_Y: cfg_in.center_y = csr_wdata[SIZE_W-1:0];
            CSR_COEFF_X:  cfg_in.coeff_x = csr_wdata[COEFF_W-1:0];
            CSR_COEFF_Y:  cfg_in.coeff_y = csr_wdata[COEFF_W-1:0];
            CSR_SCALE:    cfg_in.scale = csr_wdata[SCALE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x <= SIZE_X_RST;
         cfg_ff.size_y <= SIZE_Y_RST;
         cfg_ff.center_x <= CENTER_X_RST;
         cfg_ff.center_y <= CENTER_Y_RST;
         cfg_ff.coeff_x <= COEFF_X_RST;
         cfg_ff.coeff_y <= COEFF_Y_RST;
         cfg_ff.scale <= SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ghs_front #(
      .GRID_MAX (GRID_MAX)
   ) u_front (
      .req    (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_wr   (q_wr)
   );

   ghs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   ghs_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .q_rd  (q_rd),
      .q_pop (q_pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ghs_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 100;
   localparam int PRINT_MAX    = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0]          LOG2E_FIX  = 64'd24204406;
   localparam logic [63:0]          EXP_CLAMP  = 64'd32 << 24;
   localparam logic [HEAT_W-1:0]    HEAT_MAX   = '1;

   typedef struct packed {
      logic [HEAT_W-1:0] heat;
      logic              out_of_grid;
   } heat_result_type;

   class heat_checker;
      cfg_type         cfg;
      logic [31:0]     roots [1:ROOT_BITS];
      heat_result_type heat_pending [$];
      int              mismatches;

      function new();
         mismatches   = 0;
         cfg.size_x   = SIZE_X_RST;
         cfg.size_y   = SIZE_Y_RST;
         cfg.center_x = CENTER_X_RST;
         cfg.center_y = CENTER_Y_RST;
         cfg.coeff_x  = COEFF_X_RST;
         cfg.coeff_y  = COEFF_Y_RST;
         cfg.scale    = SCALE_RST;
         build_roots();
      endfunction

      function logic [31:0] floor_sqrt(logic [63:0] v);
         logic [31:0] r;
         logic [31:0] trial;
         r = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) r = trial;
         end
         return r;
      endfunction

      function void build_roots();
         roots[1] = floor_sqrt(64'h8000_0000_0000_0000);
         for (int i = 2; i <= ROOT_BITS; i++) roots[i] = floor_sqrt({roots[i-1], 32'b0});
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SIZE_X:   cfg.size_x   = data[SIZE_W-1:0];
            CSR_SIZE_Y:   cfg.size_y   = data[SIZE_W-1:0];
            CSR_CENTER_X: cfg.center_x = data[SIZE_W-1:0];
            CSR_CENTER_Y: cfg.center_y = data[SIZE_W-1:0];
            CSR_COEFF_X:  cfg.coeff_x  = data[COEFF_W-1:0];
            CSR_COEFF_Y:  cfg.coeff_y  = data[COEFF_W-1:0];
            CSR_SCALE:    cfg.scale    = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function heat_result_type gauss_heat(logic [IDX_W-1:0] xi, logic [IDX_W-1:0] yi);
         heat_result_type   r;
         logic [SIZE_W-1:0] lim_x, lim_y, cx, cy, dx, dy;
         logic [63:0]       e, t, n, m;
         logic [15:0]       f;
         logic [111:0]      prod;
         r.heat        = '0;
         r.out_of_grid = 1'b0;
         lim_x = (cfg.size_x > GRID_MAX_DEF) ? SIZE_W'(GRID_MAX_DEF) : cfg.size_x;
         lim_y = (cfg.size_y > GRID_MAX_DEF) ? SIZE_W'(GRID_MAX_DEF) : cfg.size_y;
         if (SIZE_W'(xi) >= lim_x || SIZE_W'(yi) >= lim_y) begin
            r.out_of_grid = 1'b1;
            return r;
         end
         cx = SIZE_W'(xi) + SIZE_W'(1);
         cy = SIZE_W'(yi) + SIZE_W'(1);
         dx = (cx >= cfg.center_x) ? cx - cfg.center_x : cfg.center_x - cx;
         dy = (cy >= cfg.center_y) ? cy - cfg.center_y : cfg.center_y - cy;
         e = 64'(dx) * 64'(dx) * 64'(cfg.coeff_x) + 64'(dy) * 64'(dy) * 64'(cfg.coeff_y);
         if (e >= EXP_CLAMP) return r;
         t = (e * LOG2E_FIX) >> 24;
         n = t >> 24;
         f = t[23:8];
         m = 64'd1 << 31;
         for (int i = 1; i <= ROOT_BITS; i++) begin
            if (f[ROOT_BITS-i]) m = (m * 64'(roots[i])) >> 32;
         end
         prod = (112'(cfg.scale) * 112'(m)) >> (31 + n);
         r.heat = (prod > 112'(HEAT_MAX)) ? HEAT_MAX : prod[HEAT_W-1:0];
         return r;
      endfunction

      function void report(string what);
         if (mismatches < PRINT_MAX) $display("mismatch: %s", what);
         mismatches++;
      endfunction

      function void note_request(logic [IDX_W-1:0] xi, logic [IDX_W-1:0] yi);
         heat_pending = {heat_pending, gauss_heat(xi, yi)};
      endfunction

      function void check_response(logic [HEAT_W-1:0] heat, logic oog);
         heat_result_type want;
         if (heat_pending.size() == 0) begin
            report($sformatf("response with none pending: heat=%0h out_of_grid=%0b", heat, oog));
            return;
         end
         want = heat_pending.pop_front();
         if (heat !== want.heat)
            report($sformatf("heat %0h, predicted %0h", heat, want.heat));
         if (oog !== want.out_of_grid)
            report($sformatf("out_of_grid %0b, predicted %0b", oog, want.out_of_grid));
      endfunction

      function int pending();
         return heat_pending.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_calm;
   logic                  rsp_calm;
   int unsigned           cycle_count = 0;
   heat_checker           chk;

   ghs_req_if req_if ();
   ghs_rsp_if rsp_if ();

   gaussian_heat_source_grid_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      chk.set_register(idx, data);
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [CSR_DATA_W-1:0] field,
                                                       int width);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      return (junk[CSR_DATA_W-1:0] << width) | field;
   endfunction

   task automatic apply_settings(cfg_type s);
      csr_write(CSR_SIZE_X,   with_junk(CSR_DATA_W'(s.size_x), SIZE_W));
      csr_write(CSR_SIZE_Y,   with_junk(CSR_DATA_W'(s.size_y), SIZE_W));
      csr_write(CSR_CENTER_X, with_junk(CSR_DATA_W'(s.center_x), SIZE_W));
      csr_write(CSR_CENTER_Y, with_junk(CSR_DATA_W'(s.center_y), SIZE_W));
      csr_write(CSR_COEFF_X,  with_junk(CSR_DATA_W'(s.coeff_x), COEFF_W));
      csr_write(CSR_COEFF_Y,  with_junk(CSR_DATA_W'(s.coeff_y), COEFF_W));
      csr_write(CSR_SCALE,    s.scale);
      csr_write(CSR_UNUSED,   with_junk('0, 0));
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (chk.pending() != 0) @(negedge clock);
   endtask

   task automatic send_request(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.x_index <= x;
      req_if.y_index <= y;
      do @(posedge clock); while (!req_if.ready);
      chk.note_request(x, y);
      @(negedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] random_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(1, 3));
         2:       return SIZE_W'(1024);
         3:       return SIZE_W'($urandom_range(1025, 2047));
         default: return SIZE_W'($urandom_range(16, 1024));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] random_centre();
      if ($urandom_range(0, 5) == 0) return SIZE_W'($urandom_range(1025, 2047));
      return SIZE_W'($urandom_range(0, 1024));
   endfunction

   function automatic logic [COEFF_W-1:0] random_coeff();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type     s;
      logic [63:0] w;
      s.size_x   = random_size();
      s.size_y   = random_size();
      s.center_x = random_centre();
      s.center_y = random_centre();
      s.coeff_x  = random_coeff();
      s.coeff_y  = random_coeff();
      w          = {$urandom, $urandom};
      s.scale    = w[SCALE_W-1:0] >> $urandom_range(0, SCALE_W - 1);
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] near_point(logic [SIZE_W-1:0] centre,
                                                   logic [SIZE_W-1:0] size, int radius);
      int lim;
      int p;
      lim = (size > GRID_MAX_DEF) ? GRID_MAX_DEF : int'(size);
      if (lim == 0) lim = 1;
      p = int'(centre) - 1 + int'($urandom_range(0, 2 * radius)) - radius;
      if (p < 0) p = 0;
      if (p > lim - 1) p = lim - 1;
      return IDX_W'(p);
   endfunction

   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         chk.check_response(rsp_if.heat, rsp_if.out_of_grid);
         @(negedge clock);
      end
   end

   initial begin
      cfg_type s;
      int      radius;
      chk = new();
      req_calm       = 1'b0;
      rsp_calm       = 1'b0;
      req_if.valid   <= 1'b0;
      req_if.x_index <= '0;
      req_if.y_index <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(10'd0, 10'd0);
      send_request(10'd1, 10'd1);
      send_request(10'd2, 10'd0);
      send_request(10'd0, 10'd3);
      send_request(10'd1023, 10'd1023);
      send_request(10'd5, 10'd2);
      drain();

      s = chk.cfg;
      s.size_x = 11'd1;
      s.size_y = 11'd1;
      apply_settings(s);
      send_request(10'd0, 10'd0);
      send_request(10'd1, 10'd0);
      send_request(10'd0, 10'd1);
      send_request(10'd1023, 10'd0);
      drain();

      s.size_x = '0;
      s.size_y = '0;
      apply_settings(s);
      send_request(10'd0, 10'd0);
      drain();

      s.size_x   = 11'd2047;
      s.size_y   = 11'd2047;
      s.center_x = 11'd2047;
      s.center_y = 11'd2047;
      s.coeff_x  = '0;
      s.coeff_y  = '0;
      s.scale    = '1;
      apply_settings(s);
      send_request(10'd1023, 10'd1023);
      send_request(10'd0, 10'd0);
      drain();

      s.size_x   = 11'd1023;
      s.size_y   = 11'd1024;
      s.center_x = 11'd1023;
      s.center_y = 11'd1;
      s.coeff_x  = '1;
      s.coeff_y  = (32'd1 << 29) - 32'd1;
      apply_settings(s);
      send_request(10'd1022, 10'd0);
      send_request(10'd1022, 10'd1);
      send_request(10'd1023, 10'd0);
      send_request(10'd1021, 10'd0);
      drain();

      s.coeff_y = 32'd1 << 29;
      apply_settings(s);
      send_request(10'd1022, 10'd1);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         s        = random_settings();
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         apply_settings(s);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            radius = 1 << $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
               send_request(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)));
            else
               send_request(near_point(s.center_x, s.size_x, radius),
                            near_point(s.center_y, s.size_y, radius));
            if ($urandom_range(0, 199) == 0) drain();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chk.mismatches == 0 && chk.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
